// ===== rtl/basic_keyword_tokenizer_top_defines.svh =====
// Assertion macros for the keyword tokenizer RTL.
`ifndef BASIC_KEYWORD_TOKENIZER_TOP_DEFINES_SVH
`define BASIC_KEYWORD_TOKENIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define BKT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// expression must never be true out of reset
`define BKT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define BKT_ASSERT(lbl, prop, msg)
`define BKT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/bkt_pkg.sv =====
// Shared types, constants and keyword ROM for the keyword tokenizer.
package bkt_pkg;

    localparam int          KW_MAX_LEN = 7;
    localparam int          KW_TEXT_W  = KW_MAX_LEN * 8;
    localparam int          KW_REM     = 29;
    localparam int          KW_DATA    = 17;
    localparam int          OBUF_DEPTH = 16;
    localparam logic [7:0]  TOKEN_BASE = 8'd128;
    localparam logic [7:0]  CH_LO      = 8'h20;
    localparam logic [7:0]  CH_HI      = 8'h7E;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_APOS    = 8'h27;
    localparam logic [7:0]  CH_COLON   = 8'h3A;
    localparam logic [7:0]  CH_EOP     = 8'h55;

    localparam logic [1:0]  OP_CHAR = 2'd0;
    localparam logic [1:0]  OP_EOL  = 2'd1;
    localparam logic [1:0]  OP_EOP  = 2'd2;
    localparam logic [1:0]  OP_NONE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_BEGIN, S_CHAR, S_HDR, S_LS, S_PRE, S_POST, S_PROC,
        S_SCAN, S_DRAIN, S_TERM, S_EOP, S_DONE, S_OUT
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] len;
    } match_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // keyword text, last character in the low byte; dialect selects the keyword set
    function automatic logic [KW_TEXT_W-1:0] kw_text(input logic [1:0] dialect,
                                                      input logic [6:0] k);
        logic [KW_TEXT_W-1:0] t;
        t = '0;
        unique case (k)
            7'd0: t = "END";
            7'd1: t = dialect[1] ? "SUBR" : "EDIT";
            7'd2: t = dialect[1] ? "WHILE" : (dialect[0] ? "STORE" : "NORMAL");
            7'd3: t = (dialect == 2'd0) ? "INVERSE" : "RECALL";
            7'd4: t = "TRON";     7'd5: t = "TROFF";    7'd6: t = "POP";
            7'd7: t = "PLOT";     7'd8: t = "PULL";     7'd9: t = "LORES";
            7'd10: t = "DOKE";    7'd11: t = "REPEAT";  7'd12: t = "UNTIL";
            7'd13: t = "FOR";     7'd14: t = "LLIST";   7'd15: t = "LPRINT";
            7'd16: t = "NEXT";    7'd17: t = "DATA";    7'd18: t = "INPUT";
            7'd19: t = "DIM";     7'd20: t = "CLS";     7'd21: t = "READ";
            7'd22: t = "LET";     7'd23: t = "GOTO";    7'd24: t = "RUN";
            7'd25: t = "IF";      7'd26: t = "RESTORE"; 7'd27: t = "GOSUB";
            7'd28: t = "RETURN";  7'd29: t = "REM";     7'd30: t = "HIMEM";
            7'd31: t = "GRAB";    7'd32: t = "RELEASE"; 7'd33: t = "TEXT";
            7'd34: t = "HIRES";   7'd35: t = "SHOOT";   7'd36: t = "EXPLODE";
            7'd37: t = "ZAP";     7'd38: t = "PING";    7'd39: t = "SOUND";
            7'd40: t = "MUSIC";   7'd41: t = "PLAY";    7'd42: t = "CURSET";
            7'd43: t = "CURMOV";  7'd44: t = "DRAW";    7'd45: t = "CIRCLE";
            7'd46: t = "PATTERN"; 7'd47: t = "FILL";    7'd48: t = "CHAR";
            7'd49: t = "PAPER";   7'd50: t = "INK";     7'd51: t = "STOP";
            7'd52: t = "ON";      7'd53: t = "WAIT";    7'd54: t = "CLOAD";
            7'd55: t = "CSAVE";   7'd56: t = "DEF";     7'd57: t = "POKE";
            7'd58: t = "PRINT";   7'd59: t = "CONT";    7'd60: t = "LIST";
            7'd61: t = "CLEAR";   7'd62: t = "GET";     7'd63: t = "CALL";
            7'd64: t = "!";       7'd65: t = "NEW";     7'd66: t = "TAB(";
            7'd67: t = "TO";      7'd68: t = "FN";      7'd69: t = "SPC(";
            7'd70: t = "@";       7'd71: t = "AUTO";    7'd72: t = "ELSE";
            7'd73: t = "THEN";    7'd74: t = "NOT";     7'd75: t = "STEP";
            7'd76: t = "+";       7'd77: t = "-";       7'd78: t = "*";
            7'd79: t = "/";       7'd80: t = "^";       7'd81: t = "AND";
            7'd82: t = "OR";      7'd83: t = ">";       7'd84: t = "=";
            7'd85: t = "<";       7'd86: t = "SGN";     7'd87: t = "INT";
            7'd88: t = "ABS";     7'd89: t = "USR";     7'd90: t = "FRE";
            7'd91: t = "POS";     7'd92: t = "HEX$";    7'd93: t = "&";
            7'd94: t = "SQR";     7'd95: t = "RND";     7'd96: t = "LN";
            7'd97: t = "EXP";     7'd98: t = "COS";     7'd99: t = "SIN";
            7'd100: t = "TAN";    7'd101: t = "ATN";    7'd102: t = "PEEK";
            7'd103: t = "DEEK";   7'd104: t = "LOG";    7'd105: t = "LEN";
            7'd106: t = "STR$";   7'd107: t = "VAL";    7'd108: t = "ASC";
            7'd109: t = "CHR$";   7'd110: t = "PI";     7'd111: t = "TRUE";
            7'd112: t = "FALSE";  7'd113: t = "KEY$";   7'd114: t = "SCRN";
            7'd115: t = "POINT";  7'd116: t = "LEFT$";  7'd117: t = "RIGHT$";
            7'd118: t = "MID$";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [KW_TEXT_W-1:0] t);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < KW_MAX_LEN; b++) begin
            if (t[b*8 +: 8] != 8'h00) n = n + 4'd1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/bkt_kw_match.sv =====
// Compares one keyword ROM entry against the head of the lookahead window.
module bkt_kw_match
    import bkt_pkg::*;
(
    input  logic [1:0] dialect,
    input  logic [6:0] kidx,
    input  logic [7:0] win [KW_MAX_LEN+1],
    output match_t     result
);

    logic [KW_TEXT_W-1:0] text;
    logic [KW_TEXT_W-1:0] aligned;
    logic [3:0]           len;
    logic [5:0]           sh;
    logic                 chars_ok;
    logic                 tail_bad;

    always_comb begin
        text     = kw_text(dialect, kidx);
        len      = kw_len(text);
        // byte count of the shift, times eight
        sh       = {3'(KW_MAX_LEN) - len[2:0], 3'b000};
        // first character moves to the top byte
        aligned  = text << sh;
        chars_ok = (len != 4'd0);
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (4'(j) < len && win[j] != aligned[(KW_MAX_LEN-1-j)*8 +: 8]) chars_ok = 1'b0;
        end
        // extended rules: word keyword must not run into a letter or digit
        tail_bad = dialect[1] && is_alnum(text[7:0]) && is_alnum(win[len[2:0]]);
        result.hit = chars_ok && !tail_bad;
        result.len = len;
    end

endmodule

// ===== rtl/basic_keyword_tokenizer_top.sv =====
// Top level of the line-numbered BASIC keyword tokenizer.
//
// Input channel s_*: one transaction per source item. s_tuser[1:0] is the
// item kind (character, end of line, end of program), s_tdata[7:0] the
// character. Result channel m_*: tokenized program bytes in m_tdata, m_tlast
// on the final byte an input transaction produced, m_tuser the sticky error
// flag as it stands after that input was handled.
// cfg_wr_en/cfg_wr_data write the dialect register; write it only when idle.
//
// Throughput: the block takes one transaction, works on it, then offers its
// bytes; s_tready is low until every byte has been taken. A lookahead
// position is resolved by a single keyword comparator that walks the ROM one
// entry per cycle until a hit or the end of the ROM; an end of line drains
// up to WINDOW_DEPTH-1 positions. All results of an input are buffered
// (16 deep) before the first is shown. Reset clears all control state and
// sets dialect 1; an end-of-program transaction clears the line number, the
// error flag and the line state before its bytes are offered. A stalled
// receiver simply holds the block in its output phase.
`include "basic_keyword_tokenizer_top_defines.svh"

module basic_keyword_tokenizer_top
    import bkt_pkg::*;
#(
    parameter int WINDOW_DEPTH  = 8,
    parameter int KEYWORD_COUNT = 119
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] ch
    input  logic [1:0] s_tuser,    // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser,    // [0] bad_char
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int LW = $clog2(2 * WINDOW_DEPTH);
    localparam int KW = $clog2(KEYWORD_COUNT + 1);
    localparam int OW = $clog2(OBUF_DEPTH + 1);

    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    logic [1:0]     op_reg, op_next;
    logic [7:0]     ch_reg, ch_next;
    logic [1:0]     dialect_reg;
    logic [7:0]     la_reg [WINDOW_DEPTH];
    logic [7:0]     la_next [WINDOW_DEPTH];
    logic [FW-1:0]  fill_reg, fill_next;
    logic [15:0]    line_num_reg, line_num_next;
    logic           in_remark_reg, in_remark_next;
    logic           in_string_reg, in_string_next;
    logic           in_data_reg, in_data_next;
    logic           in_ident_reg, in_ident_next;
    logic           hdr_done_reg, hdr_done_next;
    logic           line_start_reg, line_start_next;
    logic           err_reg, err_next;
    logic           line_open_reg, line_open_next;
    logic           digits_reg, digits_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [KW-1:0]  kidx_reg, kidx_next;
    logic [7:0]     obuf_reg [OBUF_DEPTH];
    logic [OW-1:0]  ocnt_reg, ocnt_next;
    logic [OW-1:0]  ordp_reg, ordp_next;
    logic           obad_reg, obad_next;

    // combinational controls
    logic           push_en;
    logic [7:0]     push_byte;
    logic           pop_en;
    logic [3:0]     pop_n;
    logic           wr_en;
    logic           clear_line;
    logic           ext;
    logic [7:0]     c0;
    logic [7:0]     win [KW_MAX_LEN+1];
    match_t         kw_res;
    logic           scan_end;
    logic           found;
    logic [LW-1:0]  src;
    logic           out_last;

    assign ext = dialect_reg[1];
    assign c0  = la_reg[0];

    always_comb begin
        for (int j = 0; j <= KW_MAX_LEN; j++) win[j] = la_reg[j];
    end

    bkt_kw_match u_match (
        .dialect (dialect_reg),
        .kidx    (kidx_reg[6:0]),
        .win     (win),
        .result  (kw_res)
    );

    assign scan_end = (kidx_reg == KW'(KEYWORD_COUNT));
    assign found    = !scan_end && kw_res.hit;
    assign out_last = (ordp_reg + OW'(1)) == ocnt_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = obuf_reg[ordp_reg[OW-2:0]];
    assign m_tlast  = out_last;
    assign m_tuser  = obad_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        fill_next       = fill_reg;
        line_num_next   = line_num_reg;
        in_remark_next  = in_remark_reg;
        in_string_next  = in_string_reg;
        in_data_next    = in_data_reg;
        in_ident_next   = in_ident_reg;
        hdr_done_next   = hdr_done_reg;
        line_start_next = line_start_reg;
        err_next        = err_reg;
        line_open_next  = line_open_reg;
        digits_next     = digits_reg;
        cnt_next        = cnt_reg;
        kidx_next       = kidx_reg;
        ocnt_next       = ocnt_reg;
        ordp_next       = ordp_reg;
        obad_next       = obad_reg;
        push_en         = 1'b0;
        push_byte       = 8'h00;
        pop_en          = 1'b0;
        pop_n           = 4'd1;
        wr_en           = 1'b0;
        clear_line      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    ch_next   = s_tdata;
                    ocnt_next = '0;
                    ordp_next = '0;
                    if (s_tuser != OP_NONE) state_next = S_BEGIN;
                end
            end
            S_BEGIN: begin
                if (op_reg == OP_EOP && !line_open_reg) begin
                    cnt_next   = 2'd0;
                    state_next = S_EOP;
                end else begin
                    if (!line_open_reg) begin
                        line_num_next  = ext ? line_num_reg + 16'd1 : 16'd0;
                        line_open_next = 1'b1;
                    end
                    cnt_next = 2'd0;
                    priority if (op_reg == OP_CHAR) state_next = S_CHAR;
                    else if (hdr_done_reg)          state_next = S_DRAIN;
                    else                            state_next = S_HDR;
                end
            end
            S_CHAR: begin
                priority if (hdr_done_reg) begin
                    state_next = S_LS;
                end else if (!ext && !digits_reg && ch_reg == CH_SPACE) begin
                    state_next = S_DONE;
                end else if (!ext && ch_reg >= 8'h30 && ch_reg <= 8'h39) begin
                    // n*10 + digit, wraps at 16 bits
                    line_num_next = (line_num_reg << 3) + (line_num_reg << 1)
                                    + {12'd0, ch_reg[3:0]};
                    digits_next   = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_HDR;
                end
            end
            S_HDR: begin
                push_en = 1'b1;
                unique case (cnt_reg)
                    2'd2:    push_byte = line_num_reg[7:0];
                    2'd3:    push_byte = line_num_reg[15:8];
                    default: push_byte = 8'h00;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    hdr_done_next = 1'b1;
                    state_next    = (op_reg == OP_CHAR) ? S_LS : S_DRAIN;
                end
            end
            S_LS: begin
                if (line_start_reg && ext && ch_reg == CH_SPACE) begin
                    push_en    = 1'b1;
                    push_byte  = ch_reg;
                    state_next = S_DONE;
                end else begin
                    line_start_next = 1'b0;
                    state_next      = S_PRE;
                end
            end
            S_PRE: begin
                if (fill_reg >= FW'(WINDOW_DEPTH)) begin
                    ret_next   = S_PRE;
                    state_next = S_PROC;
                end else begin
                    wr_en      = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (fill_reg >= FW'(WINDOW_DEPTH)) begin
                    ret_next   = S_POST;
                    state_next = S_PROC;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DRAIN: begin
                if (fill_reg != '0) begin
                    ret_next   = S_DRAIN;
                    state_next = S_PROC;
                end else begin
                    state_next = S_TERM;
                end
            end
            S_PROC: begin
                priority if (in_remark_reg) begin
                    push_en    = 1'b1;
                    push_byte  = c0;
                    pop_en     = 1'b1;
                    state_next = ret_reg;
                end else if (in_string_reg) begin
                    if (c0 == CH_QUOTE) in_string_next = 1'b0;
                    push_en    = 1'b1;
                    push_byte  = c0;
                    pop_en     = 1'b1;
                    state_next = ret_reg;
                end else if (in_data_reg) begin
                    if (c0 == CH_COLON) in_data_next = 1'b0;
                    if (c0 == CH_QUOTE) in_string_next = 1'b1;
                    push_en    = 1'b1;
                    push_byte  = c0;
                    pop_en     = 1'b1;
                    state_next = ret_reg;
                end else if (in_ident_reg && is_alnum(c0)) begin
                    push_en    = 1'b1;
                    push_byte  = c0;
                    pop_en     = 1'b1;
                    state_next = ret_reg;
                end else begin
                    in_ident_next = 1'b0;
                    if (c0 == CH_SPACE) begin
                        pop_en     = 1'b1;
                        state_next = ret_reg;
                    end else begin
                        kidx_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end || kw_res.hit) begin
                    if ((found && kidx_reg == KW'(KW_REM)) || c0 == CH_APOS)
                        in_remark_next = 1'b1;
                    if (found && kidx_reg == KW'(KW_DATA)) in_data_next = 1'b1;
                    if (c0 == CH_QUOTE) in_string_next = 1'b1;
                    pop_en = 1'b1;
                    priority if (found) begin
                        push_en   = 1'b1;
                        push_byte = 8'({1'b0, kidx_reg[6:0]}) + TOKEN_BASE;
                        pop_n     = kw_res.len;
                    end else if (c0 < CH_LO || c0 > CH_HI) begin
                        err_next = 1'b1;
                    end else begin
                        if (ext && is_alpha(c0)) in_ident_next = 1'b1;
                        push_en   = 1'b1;
                        push_byte = c0;
                    end
                    state_next = ret_reg;
                end else begin
                    kidx_next = kidx_reg + KW'(1);
                end
            end
            S_TERM: begin
                push_en    = 1'b1;
                push_byte  = 8'h00;
                clear_line = 1'b1;
                cnt_next   = 2'd0;
                state_next = (op_reg == OP_EOP) ? S_EOP : S_DONE;
            end
            S_EOP: begin
                push_en   = 1'b1;
                push_byte = (cnt_reg == 2'd2) ? CH_EOP : 8'h00;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) state_next = S_DONE;
            end
            S_DONE: begin
                obad_next = err_reg;
                if (op_reg == OP_EOP) begin
                    line_num_next = 16'd0;
                    err_next      = 1'b0;
                    clear_line    = 1'b1;
                end
                state_next = (ocnt_reg == '0) ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    ordp_next = ordp_reg + OW'(1);
                    if (out_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // excess results are dropped
        if (push_en && ocnt_reg != OW'(OBUF_DEPTH)) ocnt_next = ocnt_reg + OW'(1);

        // window: shift out popped characters, append new character
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            src = LW'(i) + LW'(pop_n);
            if (!pop_en)                       la_next[i] = la_reg[i];
            else if (src < LW'(WINDOW_DEPTH))  la_next[i] = la_reg[src[IW-1:0]];
            else                               la_next[i] = 8'h00;
        end
        if (pop_en) fill_next = fill_reg - FW'(pop_n);
        if (wr_en) la_next[fill_reg[IW-1:0]] = ch_reg;

        if (clear_line) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) la_next[i] = 8'h00;
            fill_next       = '0;
            in_remark_next  = 1'b0;
            in_string_next  = 1'b0;
            in_data_next    = 1'b0;
            in_ident_next   = 1'b0;
            hdr_done_next   = 1'b0;
            line_start_next = 1'b1;
            line_open_next  = 1'b0;
            digits_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            dialect_reg    <= 2'd1;
            for (int i = 0; i < WINDOW_DEPTH; i++) la_reg[i] <= 8'h00;
            fill_reg       <= '0;
            line_num_reg   <= 16'd0;
            in_remark_reg  <= 1'b0;
            in_string_reg  <= 1'b0;
            in_data_reg    <= 1'b0;
            in_ident_reg   <= 1'b0;
            hdr_done_reg   <= 1'b0;
            line_start_reg <= 1'b1;
            err_reg        <= 1'b0;
            line_open_reg  <= 1'b0;
            digits_reg     <= 1'b0;
            cnt_reg        <= 2'd0;
            kidx_reg       <= '0;
            ocnt_reg       <= '0;
            ordp_reg       <= '0;
            obad_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            if (cfg_wr_en) dialect_reg <= cfg_wr_data;
            la_reg         <= la_next;
            fill_reg       <= fill_next;
            line_num_reg   <= line_num_next;
            in_remark_reg  <= in_remark_next;
            in_string_reg  <= in_string_next;
            in_data_reg    <= in_data_next;
            in_ident_reg   <= in_ident_next;
            hdr_done_reg   <= hdr_done_next;
            line_start_reg <= line_start_next;
            err_reg        <= err_next;
            line_open_reg  <= line_open_next;
            digits_reg     <= digits_next;
            cnt_reg        <= cnt_next;
            kidx_reg       <= kidx_next;
            ocnt_reg       <= ocnt_next;
            ordp_reg       <= ordp_next;
            obad_reg       <= obad_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        ch_reg <= ch_next;
        if (push_en && ocnt_reg != OW'(OBUF_DEPTH)) obuf_reg[ocnt_reg[OW-2:0]] <= push_byte;
    end

    `BKT_NEVER(a_no_overlap, s_tready && m_tvalid, "input and output phases overlap")
    `BKT_NEVER(a_fill_bound, fill_reg > FW'(WINDOW_DEPTH), "window overfilled")
    `BKT_NEVER(a_ocnt_bound, ocnt_reg > OW'(OBUF_DEPTH), "result buffer overrun")
    `BKT_ASSERT(a_last_ends, m_tvalid && m_tready && m_tlast |=> !m_tvalid,
                "results continue after last")

endmodule
